// ===== design/gws_pkg.sv =====
`timescale 1ns / 1ps

package gws_pkg;

    localparam int unsigned XW = 61;
    localparam int unsigned TERM_W = 57;
    localparam int unsigned ACC_W = 48;
    localparam int unsigned TAYLOR_TERMS = 24;
    localparam int unsigned QDEPTH = 2;

    localparam logic [55:0] LN2_Q56 = 56'hB17217F7D1CF7A;
    localparam logic [56:0] ONE_Q56 = 57'h100000000000000;
    localparam logic [95:0] X_LIMIT = 96'd23 << 56;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    typedef struct packed {
        logic          big;
        logic [XW-1:0] x;
        logic          last;
    } t_queue_word;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQUARE,
        F_SCALE,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EXP,
        B_ADD
    } t_back_state;

    typedef enum logic [2:0] {
        E_IDLE,
        E_RANGE,
        E_MUL,
        E_DIV,
        E_ACC,
        E_ROUND
    } t_exp_state;

endpackage

// ===== design/gaussian_weight_stream_sum.sv =====
`timescale 1ns / 1ps

// Sums exp(-t*g*g) over a pass of signed Q16.16 samples and emits twice the sum.
// The input stream carries one sample per word in tdata, with tlast marking the
// final sample of a pass. Each accepted word is squared and scaled by the heat
// time, then queued; the exponential unit reduces the argument by ln 2 and runs
// 24 series terms, each a four-part multiply and a bit-serial division by the
// term index. A sample whose scaled square is 23 or more skips the unit. The
// series unit sets the throughput.
// On the last sample of a pass the output stream presents one word holding twice
// the saturated 48-bit sum, and the sum is cleared. The output register holds its
// word while the receiver stalls; the front end keeps accepting samples until the
// two-entry queue is full. The user must write heat time through the configuration
// port only while idle; the block does not enforce this. Reset clears the sum, the
// queue and the output valid, and sets the heat time to 1.0.

module gaussian_weight_stream_sum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // gamma_value[31:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // gauss_sum[48:0], zeros above
);

    logic [31:0] r_heat_time;
    logic        push, full, pop, empty;
    gws_pkg::t_queue_word push_word, pop_word;
    logic [48:0] gauss_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_time <= 32'h01000000;
        end else if (i_cfg_wr_en) begin
            r_heat_time <= i_cfg_wr_data;
        end
    end

    gws_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_gamma_value (s_axis_tdata),
        .i_last_item   (s_axis_tlast),
        .i_heat_time   (r_heat_time),
        .o_push        (push),
        .o_word        (push_word),
        .i_full        (full)
    );

    gws_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_full  (full),
        .i_pop   (pop),
        .o_word  (pop_word),
        .o_empty (empty)
    );

    gws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (pop_word),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_gauss_sum (gauss_sum)
    );

    assign m_axis_tdata = {7'd0, gauss_sum};

endmodule

// ===== design/gws_front.sv =====
`timescale 1ns / 1ps

module gws_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_gamma_value,
    input  logic                 i_last_item,
    input  logic [31:0]          i_heat_time,
    output logic                 o_push,
    output gws_pkg::t_queue_word o_word,
    input  logic                 i_full
);

    gws_pkg::t_front_state r_state, n_state;
    logic [31:0] r_mag;
    logic        r_last;
    logic [63:0] r_g2;
    logic [63:0] r_plo, r_phi;
    logic [31:0] mag;
    logic [95:0] x;

    assign mag = i_gamma_value[31] ? (32'd0 - i_gamma_value) : i_gamma_value;
    assign x = {32'd0, r_plo} + {r_phi, 32'd0};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gws_pkg::F_IDLE:   if (i_valid) n_state = gws_pkg::F_SQUARE;
            gws_pkg::F_SQUARE: n_state = gws_pkg::F_SCALE;
            gws_pkg::F_SCALE:  n_state = gws_pkg::F_PUSH;
            gws_pkg::F_PUSH:   if (!i_full) n_state = gws_pkg::F_IDLE;
            default:           n_state = gws_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == gws_pkg::F_IDLE);
        o_push = (r_state == gws_pkg::F_PUSH) && !i_full;
        o_word.big = (x >= gws_pkg::X_LIMIT);
        o_word.x = x[gws_pkg::XW-1:0];
        o_word.last = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gws_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (o_ready && i_valid) begin
            r_mag <= mag;
            r_last <= i_last_item;
        end
        r_g2 <= r_mag * r_mag;
        r_plo <= i_heat_time * r_g2[31:0];
        r_phi <= i_heat_time * r_g2[63:32];
    end

endmodule

// ===== design/gws_fifo.sv =====
`timescale 1ns / 1ps

module gws_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  gws_pkg::t_queue_word i_word,
    output logic                 o_full,
    input  logic                 i_pop,
    output gws_pkg::t_queue_word o_word,
    output logic                 o_empty
);

    gws_pkg::t_queue_word r_mem [gws_pkg::QDEPTH];
    logic r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full = (r_count == 2'(gws_pkg::QDEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_word = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop) r_rd_ptr <= ~r_rd_ptr;
            if (i_push && !i_pop) r_count <= r_count + 2'd1;
            else if (!i_push && i_pop) r_count <= r_count - 2'd1;
        end
        if (i_push) r_mem[r_wr_ptr] <= i_word;
    end

endmodule

// ===== design/gws_exp.sv =====
`timescale 1ns / 1ps

module gws_exp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gws_pkg::XW-1:0]     i_x,
    output logic                       o_done,
    output logic [31:0]                o_term
);

    gws_pkg::t_exp_state r_state, n_state;
    logic [gws_pkg::XW-1:0]     r_r;
    logic [5:0]                 r_k;
    logic [gws_pkg::TERM_W-1:0] r_term;
    logic [gws_pkg::TERM_W-1:0] r_quo;
    logic [63:0]                r_pos, r_neg;
    logic [4:0]                 r_n;
    logic [4:0]                 r_rem;
    logic [5:0]                 r_step;
    logic [63:0]                r_prod;
    logic [112:0]               r_macc;
    logic                       r_done;
    logic [31:0]                r_res;

    logic        reduce;
    logic [31:0] a_sel, b_sel;
    logic [1:0]  pidx;
    logic [112:0] macc_next;
    logic [5:0]  rem2;
    logic        qbit;
    logic [5:0]  rem_sub;
    logic [63:0] e;
    logic [6:0]  sh;
    logic [64:0] rnd;
    logic        mul_last, div_last, acc_last;

    always_comb begin
        reduce = (r_r >= {5'd0, gws_pkg::LN2_Q56});
        a_sel = r_step[1] ? {7'd0, r_term[56:32]} : r_term[31:0];
        b_sel = r_step[0] ? {8'd0, r_r[55:32]} : r_r[31:0];
        pidx = 2'(r_step - 6'd1);
        macc_next = r_macc + ({49'd0, r_prod} << (7'd32 * ({6'd0, pidx[1]} + {6'd0, pidx[0]})));
        rem2 = {r_rem, r_quo[gws_pkg::TERM_W-1]};
        qbit = (rem2 >= {1'b0, r_n});
        rem_sub = qbit ? (rem2 - {1'b0, r_n}) : rem2;
        e = r_pos - r_neg;
        sh = 7'd24 + {1'b0, r_k};
        rnd = ({1'b0, e} + (65'd1 << (sh - 7'd1))) >> sh;
        mul_last = (r_step == 6'd4);
        div_last = (r_step == 6'(gws_pkg::TERM_W - 1));
        acc_last = (r_n == 5'(gws_pkg::TAYLOR_TERMS));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gws_pkg::E_IDLE:  if (i_start) n_state = gws_pkg::E_RANGE;
            gws_pkg::E_RANGE: if (!reduce) n_state = gws_pkg::E_MUL;
            gws_pkg::E_MUL:   if (mul_last) n_state = gws_pkg::E_DIV;
            gws_pkg::E_DIV:   if (div_last) n_state = gws_pkg::E_ACC;
            gws_pkg::E_ACC:   n_state = acc_last ? gws_pkg::E_ROUND : gws_pkg::E_MUL;
            gws_pkg::E_ROUND: n_state = gws_pkg::E_IDLE;
            default:          n_state = gws_pkg::E_IDLE;
        endcase
    end

    always_comb begin
        o_done = r_done;
        o_term = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gws_pkg::E_IDLE;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= (r_state == gws_pkg::E_ROUND);
        end
        unique case (r_state)
            gws_pkg::E_IDLE: begin
                r_r <= i_x;
                r_k <= 6'd0;
                r_term <= gws_pkg::ONE_Q56;
                r_pos <= {7'd0, gws_pkg::ONE_Q56};
                r_neg <= 64'd0;
                r_n <= 5'd1;
                r_step <= 6'd0;
                r_macc <= '0;
            end
            gws_pkg::E_RANGE: begin
                if (reduce) begin
                    r_r <= r_r - {5'd0, gws_pkg::LN2_Q56};
                    r_k <= r_k + 6'd1;
                end
            end
            gws_pkg::E_MUL: begin
                r_prod <= a_sel * b_sel;
                if (r_step != 6'd0) r_macc <= macc_next;
                if (mul_last) begin
                    r_quo <= macc_next[112:56];
                    r_rem <= 5'd0;
                    r_step <= 6'd0;
                end else begin
                    r_step <= r_step + 6'd1;
                end
            end
            gws_pkg::E_DIV: begin
                r_quo <= {r_quo[gws_pkg::TERM_W-2:0], qbit};
                r_rem <= rem_sub[4:0];
                r_step <= div_last ? 6'd0 : r_step + 6'd1;
            end
            gws_pkg::E_ACC: begin
                r_term <= r_quo;
                if (r_n[0]) r_neg <= r_neg + {7'd0, r_quo};
                else r_pos <= r_pos + {7'd0, r_quo};
                r_n <= r_n + 5'd1;
                r_macc <= '0;
                r_step <= 6'd0;
            end
            gws_pkg::E_ROUND: begin
                r_res <= (rnd > 65'hFFFFFFFF) ? 32'hFFFFFFFF : rnd[31:0];
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/gws_back.sv =====
`timescale 1ns / 1ps

module gws_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gws_pkg::t_queue_word i_word,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [48:0]          o_gauss_sum
);

    gws_pkg::t_back_state r_state, n_state;
    logic [gws_pkg::ACC_W-1:0] r_acc;
    logic [31:0]               r_term;
    logic                      r_last;
    logic                      r_out_valid;
    logic [48:0]               r_out;

    logic        exp_start, exp_done;
    logic [31:0] exp_term;
    logic [gws_pkg::ACC_W:0]   total;
    logic [gws_pkg::ACC_W-1:0] sat;
    logic        out_free, commit;

    gws_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (exp_start),
        .i_x     (i_word.x),
        .o_done  (exp_done),
        .o_term  (exp_term)
    );

    always_comb begin
        total = {1'b0, r_acc} + {17'd0, r_term};
        sat = total[gws_pkg::ACC_W] ? gws_pkg::ACC_MAX : total[gws_pkg::ACC_W-1:0];
        out_free = !r_out_valid || i_ready;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gws_pkg::B_IDLE: begin
                if (!i_empty) n_state = i_word.big ? gws_pkg::B_ADD : gws_pkg::B_EXP;
            end
            gws_pkg::B_EXP: if (exp_done) n_state = gws_pkg::B_ADD;
            gws_pkg::B_ADD: if (!r_last || out_free) n_state = gws_pkg::B_IDLE;
            default:        n_state = gws_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == gws_pkg::B_IDLE) && !i_empty;
        exp_start = o_pop && !i_word.big;
        commit = (r_state == gws_pkg::B_ADD) && (!r_last || out_free);
        o_valid = r_out_valid;
        o_gauss_sum = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gws_pkg::B_IDLE;
            r_acc <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) r_acc <= r_last ? '0 : sat;
            if (commit && r_last) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
        if (o_pop) begin
            r_last <= i_word.last;
            r_term <= 32'd0;
        end
        if (r_state == gws_pkg::B_EXP && exp_done) r_term <= exp_term;
        if (commit && r_last) r_out <= {sat, 1'b0};
    end

endmodule
